/* hdl/dca_pkg.sv */
// ----------------------------------------------------------------------------
// dca_pkg
// shared types and constants for the descriptor chain allocator
// ----------------------------------------------------------------------------
package dca_pkg;

  // fixed field widths
  localparam int LINK_W  = 7;
  localparam int HEAD_W  = 8;
  localparam int COUNT_W = 8;

  // default pool size
  localparam int DESC_COUNT_DEF = 8;

  // descriptors taken by one allocate
  localparam int CHAIN_LEN  = 3;
  localparam int PICK_CNT_W = 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2,
    ST_ALREADY = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [HEAD_W-1:0] head_index;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic [LINK_W-1:0]  first_index;
    logic [LINK_W-1:0]  second_index;
    logic [LINK_W-1:0]  third_index;
    logic [COUNT_W-1:0] freed_count;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE_CHECK,
    S_FREE_NEXT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    pick;
    logic    walk;
    logic    follow;
    logic    finish;
    status_t fin_status;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic found;
    logic last_pick;
    logic range_err;
    logic already_err;
    logic more;
    logic bound;
  } dp_status_t;

endpackage

/* hdl/dca_ctrl.sv */
// ----------------------------------------------------------------------------
// dca_ctrl
// sequencer for allocate picks and chain free walks
// ----------------------------------------------------------------------------
module dca_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  dca_pkg::opcode_t      opcode,
  input  dca_pkg::dp_status_t   sts,
  output dca_pkg::ctrl_cmd_t    cmd,
  output logic                  busy,
  output logic                  done
);

  dca_pkg::state_t state;
  dca_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dca_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.fin_status = dca_pkg::ST_OK;
    unique case (state)
      dca_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (opcode == dca_pkg::OP_FREE) ? dca_pkg::S_FREE_CHECK
                                                    : dca_pkg::S_ALLOC;
        end
      end
      dca_pkg::S_ALLOC: begin
        if (!sts.found) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = dca_pkg::ST_NOSPACE;
          state_next     = dca_pkg::S_IDLE;
        end else begin
          cmd.pick = 1'b1;
          if (sts.last_pick) begin
            cmd.finish = 1'b1;
            state_next = dca_pkg::S_IDLE;
          end
        end
      end
      dca_pkg::S_FREE_CHECK: begin
        priority if (sts.range_err) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = dca_pkg::ST_RANGE;
          state_next     = dca_pkg::S_IDLE;
        end else if (sts.already_err) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = dca_pkg::ST_ALREADY;
          state_next     = dca_pkg::S_IDLE;
        end else begin
          cmd.walk = 1'b1;
          if (!sts.more || sts.bound) begin
            cmd.finish = 1'b1;
            state_next = dca_pkg::S_IDLE;
          end else begin
            state_next = dca_pkg::S_FREE_NEXT;
          end
        end
      end
      dca_pkg::S_FREE_NEXT: begin
        cmd.follow = 1'b1;
        state_next = dca_pkg::S_FREE_CHECK;
      end
      default: begin
        state_next = dca_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != dca_pkg::S_IDLE);

endmodule

/* hdl/dca_dp.sv */
// ----------------------------------------------------------------------------
// dca_dp
// free bitmap, link table and result register
// ----------------------------------------------------------------------------
module dca_dp #(
  parameter int DESC_COUNT = dca_pkg::DESC_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dca_pkg::request_t    request,
  input  dca_pkg::ctrl_cmd_t   cmd,
  output dca_pkg::dp_status_t  sts,
  output dca_pkg::result_t     result
);

  localparam int IDX_W = $clog2(DESC_COUNT);

  // bitmap and link-valid flags, reset directly
  logic [DESC_COUNT-1:0] free_map;
  logic [DESC_COUNT-1:0] has_next;

  // link table, only read behind a set has_next flag
  logic [IDX_W-1:0] next_link [DESC_COUNT];
  logic [IDX_W-1:0] link_rdata;

  // allocate scan
  logic [DESC_COUNT-1:0]       avail;
  logic [DESC_COUNT-1:0]       low_bit;
  logic [IDX_W-1:0]            low_idx;
  logic [dca_pkg::PICK_CNT_W-1:0] pick_cnt;
  logic [IDX_W-1:0]            pick0;
  logic [IDX_W-1:0]            pick1;

  // free walk
  logic [dca_pkg::HEAD_W-1:0]  cur;
  logic [IDX_W-1:0]            cur_idx;
  logic [dca_pkg::COUNT_W-1:0] count;
  logic [dca_pkg::COUNT_W-1:0] count_next;
  logic                        is_free_op;

  logic                        link_we;
  logic [IDX_W-1:0]            link_waddr;

  // isolate lowest free descriptor
  assign low_bit = avail & (~avail + DESC_COUNT'(1));

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < DESC_COUNT; i++) begin
      low_idx = low_idx | ({IDX_W{low_bit[i]}} & IDX_W'(i));
    end
  end

  assign cur_idx    = cur[IDX_W-1:0];
  assign count_next = count + dca_pkg::COUNT_W'(cmd.walk);

  assign sts.found       = |avail;
  assign sts.last_pick   = (pick_cnt == dca_pkg::PICK_CNT_W'(dca_pkg::CHAIN_LEN - 1));
  assign sts.range_err   = (cur >= dca_pkg::HEAD_W'(DESC_COUNT));
  assign sts.already_err = free_map[cur_idx];
  assign sts.more        = has_next[cur_idx];
  assign sts.bound       = (count == dca_pkg::COUNT_W'(DESC_COUNT - 1));

  // link writes: first -> second on second pick, second -> third on third pick
  assign link_we    = cmd.pick && (pick_cnt != '0);
  assign link_waddr = (pick_cnt == dca_pkg::PICK_CNT_W'(1)) ? pick0 : pick1;

  always_ff @(posedge clk) begin
    if (link_we) begin
      next_link[link_waddr] <= low_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk) begin
      link_rdata <= next_link[cur_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
      has_next <= '0;
    end else begin
      if (cmd.pick && sts.last_pick) begin
        free_map[pick0]   <= 1'b0;
        free_map[pick1]   <= 1'b0;
        free_map[low_idx] <= 1'b0;
        has_next[pick0]   <= 1'b1;
        has_next[pick1]   <= 1'b1;
        has_next[low_idx] <= 1'b0;
      end
      if (cmd.walk) begin
        free_map[cur_idx] <= 1'b1;
        has_next[cur_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pick_cnt <= '0;
    end else if (cmd.load) begin
      pick_cnt <= '0;
    end else if (cmd.pick) begin
      pick_cnt <= pick_cnt + dca_pkg::PICK_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      avail      <= free_map;
      cur        <= request.head_index;
      count      <= '0;
      is_free_op <= (request.opcode == dca_pkg::OP_FREE);
    end else begin
      if (cmd.pick) begin
        avail <= avail & ~low_bit;
        if (pick_cnt == '0) begin
          pick0 <= low_idx;
        end
        if (pick_cnt == dca_pkg::PICK_CNT_W'(1)) begin
          pick1 <= low_idx;
        end
      end
      if (cmd.walk) begin
        count <= count_next;
      end
      if (cmd.follow) begin
        cur <= dca_pkg::HEAD_W'(link_rdata);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.status <= cmd.fin_status;
      if (!is_free_op && cmd.fin_status == dca_pkg::ST_OK) begin
        result.first_index  <= dca_pkg::LINK_W'(pick0);
        result.second_index <= dca_pkg::LINK_W'(pick1);
        result.third_index  <= dca_pkg::LINK_W'(low_idx);
      end else begin
        result.first_index  <= '0;
        result.second_index <= '0;
        result.third_index  <= '0;
      end
      result.freed_count <= is_free_op ? count_next : '0;
    end
  end

endmodule

/* hdl/descriptor_chain_allocator_core.sv */
// ----------------------------------------------------------------------------
// descriptor_chain_allocator_core
// allocate: picks from start to done until three are taken, ending early with no-space status when under three are free
// chain free: a check step and a follow step per descriptor freed; a range or free fault ends the walk at a check
// throughput: one transaction at a time; the next start is taken with done
// reset: synchronous, all descriptors free and no links; done pulses one cycle
// and the receiver cannot stall it, so the result must be taken with done
// ----------------------------------------------------------------------------
module descriptor_chain_allocator_core #(
  parameter int DESC_COUNT = dca_pkg::DESC_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dca_pkg::request_t request,
  output logic              busy,
  output logic              done,
  output dca_pkg::result_t  result
);

  // command and status between controller and datapath
  dca_pkg::ctrl_cmd_t  cmd;
  dca_pkg::dp_status_t sts;

  // controller: idle, three allocate picks, or check/follow walk steps
  dca_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (request.opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // datapath: lowest-free search over the bitmap, one pick per cycle;
  // link table read one entry per walk step with registered data
  dca_dp #(
    .DESC_COUNT (DESC_COUNT)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result)
  );

endmodule
